@@ hdl/fir_hp_pkg.sv @@
// Shared constants, opcodes and controller/datapath command types for the FIR high-pass filter.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package fir_hp_pkg;

  localparam int TAPS        = 101;
  localparam int TAP_W       = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int IDX_W       = 8;
  localparam int SMP_W       = 16;
  localparam int PROD_W      = 2 * SMP_W;
  localparam int ACC_W       = PROD_W + $clog2(TAPS) + 1;
  localparam int FRAC_W      = 15;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int DRAIN_CYC   = 2;

  localparam logic OP_COEF   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic             coef_wr;
    logic             sample_wr;
    logic             step;
    logic [TAP_W-1:0] tap;
    logic             load;
  } fir_hp_cmd_t;

  typedef struct packed {
    logic out_free;
  } fir_hp_sts_t;

endpackage

@@ hdl/fir_hp_ctrl.sv @@
// Controller FSM for the FIR high-pass filter: accepts words, walks the taps, loads results.
// Depends on fir_hp_pkg.
module fir_hp_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tuser,
  output logic                     in_tready,
  input  fir_hp_pkg::fir_hp_sts_t  sts,
  output fir_hp_pkg::fir_hp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [fir_hp_pkg::TAP_W-1:0] tap_cnt_r, tap_cnt_nxt;
  logic                         drain_cnt_r, drain_cnt_nxt;
  logic                         accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    tap_cnt_nxt   = tap_cnt_r;
    drain_cnt_nxt = drain_cnt_r;
    cmd           = '0;
    cmd.tap       = tap_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == fir_hp_pkg::OP_SAMPLE) begin
            cmd.sample_wr = 1'b1;
            tap_cnt_nxt   = '0;
            state_nxt     = ST_RUN;
          end else begin
            cmd.coef_wr = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (tap_cnt_r == fir_hp_pkg::TAP_W'(fir_hp_pkg::TAPS - 1)) begin
          drain_cnt_nxt = 1'b0;
          state_nxt     = ST_DRAIN;
        end else begin
          tap_cnt_nxt = tap_cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt_r == 1'(fir_hp_pkg::DRAIN_CYC - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          drain_cnt_nxt = drain_cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_cnt_r   <= '0;
      drain_cnt_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_cnt_r   <= tap_cnt_nxt;
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free)
    else $error("result loaded while output register still full");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_tready)
    else $error("tap walk overlaps input acceptance");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && tap_cnt_r == fir_hp_pkg::TAP_W'(fir_hp_pkg::TAPS - 1))
      |=> (state_r == ST_DRAIN))
    else $error("tap walk did not end after last tap");

endmodule

@@ hdl/fir_hp_dp.sv @@
// Datapath for the FIR high-pass filter: sample and coefficient memories, shared MAC,
// rounding/saturation and output register. Depends on fir_hp_pkg.
module fir_hp_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fir_hp_pkg::fir_hp_cmd_t               cmd,
  output fir_hp_pkg::fir_hp_sts_t               sts,
  input  logic [fir_hp_pkg::IDX_W-1:0]          coef_index,
  input  logic signed [fir_hp_pkg::SMP_W-1:0]   coef_value,
  input  logic signed [fir_hp_pkg::SMP_W-1:0]   sample_in,
  output logic signed [fir_hp_pkg::SMP_W-1:0]   sample_out,
  output logic                                  saturated,
  output logic                                  out_tvalid,
  input  logic                                  out_tready
);

  localparam int TAPS  = fir_hp_pkg::TAPS;
  localparam int TAP_W = fir_hp_pkg::TAP_W;
  localparam int SMP_W = fir_hp_pkg::SMP_W;
  localparam int ACC_W = fir_hp_pkg::ACC_W;

  logic signed [SMP_W-1:0]            dl_mem [TAPS];
  logic signed [SMP_W-1:0]            cf_mem [TAPS];
  logic [TAPS-1:0]                    dl_vld_r;
  logic [TAPS-1:0]                    cf_vld_r;
  logic [TAP_W-1:0]                   wr_ptr_r;
  logic [TAP_W-1:0]                   rd_ptr_r;
  logic signed [SMP_W-1:0]            dl_q_r, cf_q_r;
  logic                               dl_qv_r, cf_qv_r;
  logic                               rd_v_r, mul_v_r;
  logic signed [fir_hp_pkg::PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]            acc_r;
  logic signed [SMP_W-1:0]            op_a, op_b;
  logic signed [ACC_W-1:0]            acc_adj, quot;
  logic signed [SMP_W-1:0]            res;
  logic                               res_sat;
  logic                               coef_ok;
  logic [TAP_W-1:0]                   coef_addr;
  logic                               out_valid_r;
  logic signed [SMP_W-1:0]            sample_out_r;
  logic                               saturated_r;

  assign coef_ok   = ({1'b0, coef_index} < (fir_hp_pkg::IDX_W + 1)'(TAPS));
  assign coef_addr = TAP_W'(coef_index);

  always_ff @(posedge clk) begin
    if (cmd.sample_wr) begin
      dl_mem[wr_ptr_r] <= sample_in;
    end
    if (cmd.coef_wr && coef_ok) begin
      cf_mem[coef_addr] <= coef_value;
    end
    if (cmd.step) begin
      dl_q_r <= dl_mem[rd_ptr_r];
      cf_q_r <= cf_mem[cmd.tap];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_vld_r <= '0;
      cf_vld_r <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      dl_qv_r  <= 1'b0;
      cf_qv_r  <= 1'b0;
      rd_v_r   <= 1'b0;
      mul_v_r  <= 1'b0;
    end else begin
      rd_v_r  <= cmd.step;
      mul_v_r <= rd_v_r;
      if (cmd.sample_wr) begin
        dl_vld_r[wr_ptr_r] <= 1'b1;
        rd_ptr_r           <= wr_ptr_r;
      end
      if (cmd.coef_wr && coef_ok) begin
        cf_vld_r[coef_addr] <= 1'b1;
      end
      if (cmd.step) begin
        dl_qv_r  <= dl_vld_r[rd_ptr_r];
        cf_qv_r  <= cf_vld_r[cmd.tap];
        rd_ptr_r <= (rd_ptr_r == '0) ? TAP_W'(TAPS - 1) : rd_ptr_r - 1'b1;
      end
      if (cmd.load) begin
        wr_ptr_r <= (wr_ptr_r == TAP_W'(TAPS - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
    end
  end

  assign op_a = dl_qv_r ? dl_q_r : '0;
  assign op_b = cf_qv_r ? cf_q_r : '0;

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.sample_wr) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_comb begin
    acc_adj = acc_r;
    if (acc_r[ACC_W-1]) begin
      acc_adj = acc_r + ACC_W'((1 << fir_hp_pkg::FRAC_W) - 1);
    end
    quot    = acc_adj >>> fir_hp_pkg::FRAC_W;
    res_sat = 1'b0;
    res     = quot[SMP_W-1:0];
    if (quot > ACC_W'(signed'(32767))) begin
      res     = 16'sh7FFF;
      res_sat = 1'b1;
    end else if (quot < -ACC_W'(signed'(32768))) begin
      res     = 16'sh8000;
      res_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_out_r <= res;
      saturated_r  <= res_sat;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign sample_out   = sample_out_r;
  assign saturated    = saturated_r;

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!rd_v_r && !mul_v_r))
    else $error("result loaded before MAC pipeline drained");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r <= TAP_W'(TAPS - 1)) && (rd_ptr_r <= TAP_W'(TAPS - 1)))
    else $error("delay-line pointer beyond tap count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready)
      |=> (out_valid_r && $stable(sample_out_r) && $stable(saturated_r)))
    else $error("output word changed while stalled");

endmodule

@@ hdl/fir_highpass_filter_top.sv @@
// Top level of the FIR high-pass filter: controller FSM plus MAC datapath.
// Depends on fir_hp_pkg, fir_hp_ctrl and fir_hp_dp.
//
//   channel | direction | ports                      | word
//   in_     | slave     | tvalid tready tdata tuser  | coefficient write or audio sample
//   out_    | master     | tvalid tready tdata tuser  | filtered sample and clip flag
//
// A sample word is filtered by one shared 16x16 MAC that walks the taps,
// one tap per cycle from the sample and coefficient memories, then drains its pipeline.
// A coefficient write keeps the FSM idle. Reset clears all taps and samples to zero at once.
// A finished result waits in the output register; the next word is taken meanwhile, and only
// the load of a following result stalls until the previous one is taken.
module fir_highpass_filter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fir_hp_pkg::IN_TDATA_W-1:0]   in_tdata,   // coef_index, coef_value, sample_in
  input  logic                                in_tuser,   // opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fir_hp_pkg::OUT_TDATA_W-1:0]  out_tdata,  // sample_out
  output logic                                out_tuser   // saturated
);

  fir_hp_pkg::fir_hp_cmd_t cmd;
  fir_hp_pkg::fir_hp_sts_t sts;
  logic signed [fir_hp_pkg::SMP_W-1:0] sample_out;

  fir_hp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fir_hp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .coef_index (in_tdata[7:0]),
    .coef_value (in_tdata[23:8]),
    .sample_in  (in_tdata[39:24]),
    .sample_out (sample_out),
    .saturated  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  assign out_tdata = sample_out;

endmodule
